FILE: hw/rtl/ksda_pkg.sv
package ksda_pkg;

   localparam int KEY_W       = 3;
   localparam int SAMPLE_W    = 4;
   localparam int FLAG_W      = 8;
   localparam int DELAY_W     = 15;
   localparam int COUNT_W     = 16;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 3;

   // debounce thresholds on the number of high samples
   localparam logic [SAMPLE_W-1:0] UP_ABOVE   = SAMPLE_W'(7);
   localparam logic [SAMPLE_W-1:0] DOWN_BELOW = SAMPLE_W'(3);

   localparam logic [DELAY_W-1:0] DELAY_RESET    = DELAY_W'(50);
   localparam logic [DELAY_W-1:0] INTERVAL_RESET = DELAY_W'(5);

   // register select, taken from paddr bit 2
   localparam logic REG_DELAY    = 1'b0;
   localparam logic REG_INTERVAL = 1'b1;

   localparam logic ACTION_SCAN  = 1'b0;
   localparam logic ACTION_CLEAR = 1'b1;

   typedef enum logic [1:0] {
      BEEP_NONE  = 2'd0,
      BEEP_SHORT = 2'd1,
      BEEP_LONG  = 2'd2
   } beep_type;

   typedef struct packed {
      logic             clear;
      logic             key_ok;
      logic [KEY_W-1:0] key;
      logic             go_up;
      logic             go_down;
   } cmd_type;

   typedef struct packed {
      logic [FLAG_W-1:0] pressed_flags;
      logic [FLAG_W-1:0] debounced_up;
      beep_type          beep_request;
   } rsp_type;

endpackage

FILE: hw/rtl/key_scan_debounce_autorepeat_core.sv
// Keypad debounce with auto repeat. Each item on the req side is either a scan result for
// one key (its index and how many samples read high) or a clear of all pressed flags; each
// item gives exactly one result on the rsp side with the pressed flags, the debounced
// levels and a beep request. The block sustains one item per clock while the result queue
// has room: a classifying front end feeds a two-entry command queue, the state update
// consumes one command per cycle into a two-entry result queue, registering a result as
// its command is popped. Keys at or above KEYS are ignored. The two delay registers sit at
// byte addresses 0 and 4 and should only be written while no item is in flight.
module key_scan_debounce_autorepeat_core
   import ksda_pkg::*;
#(
   parameter int KEYS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  logic                  req_action,
   input  logic [KEY_W-1:0]      req_key_index,
   input  logic [SAMPLE_W-1:0]   req_high_samples,
   output logic                  empty,
   input  logic                  pop,
   output logic [FLAG_W-1:0]     rsp_pressed_flags,
   output logic [FLAG_W-1:0]     rsp_debounced_up,
   output logic [1:0]            rsp_beep_request,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   logic [DELAY_W-1:0] delay_ff, delay_in;
   logic [DELAY_W-1:0] interval_ff, interval_in;
   logic [COUNT_W-1:0] limit_ff, limit_in;
   logic               csr_write;

   cmd_type cmd_wr, cmd_rd;
   rsp_type rsp_wr, rsp_rd;
   logic    cmd_push, cmd_full, cmd_pop, cmd_empty;
   logic    rsp_push, rsp_full;

   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite & pready;

   always_comb begin
      delay_in    = delay_ff;
      interval_in = interval_ff;
      if (csr_write) begin
         unique case (paddr[2])
            REG_DELAY:    delay_in    = pwdata[DELAY_W-1:0];
            REG_INTERVAL: interval_in = pwdata[DELAY_W-1:0];
            default:      ;
         endcase
      end
      // repeat threshold kept precomputed
      limit_in = COUNT_W'(delay_in) + COUNT_W'(interval_in);
   end

   always_comb begin
      unique case (paddr[2])
         REG_DELAY:    prdata = CSR_DATA_W'(delay_ff);
         REG_INTERVAL: prdata = CSR_DATA_W'(interval_ff);
         default:      prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff    <= DELAY_RESET;
         interval_ff <= INTERVAL_RESET;
         limit_ff    <= COUNT_W'(DELAY_RESET) + COUNT_W'(INTERVAL_RESET);
      end else begin
         delay_ff    <= delay_in;
         interval_ff <= interval_in;
         limit_ff    <= limit_in;
      end
   end

   ksda_front #(
      .KEYS (KEYS)
   ) u_front (
      .push         (push),
      .full         (full),
      .action       (req_action),
      .key_index    (req_key_index),
      .high_samples (req_high_samples),
      .cmd_push     (cmd_push),
      .cmd          (cmd_wr),
      .cmd_full     (cmd_full)
   );

   ksda_fifo #(
      .WIDTH ($bits(cmd_type)),
      .DEPTH (2)
   ) u_cmd_queue (
      .clock (clock),
      .reset (reset),
      .push  (cmd_push),
      .wdata (cmd_wr),
      .full  (cmd_full),
      .pop   (cmd_pop),
      .rdata (cmd_rd),
      .empty (cmd_empty)
   );

   ksda_back #(
      .KEYS (KEYS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd       (cmd_rd),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp       (rsp_wr),
      .reload    (delay_ff),
      .limit     (limit_ff)
   );

   ksda_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (2)
   ) u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (rsp_push),
      .wdata (rsp_wr),
      .full  (rsp_full),
      .pop   (pop),
      .rdata (rsp_rd),
      .empty (empty)
   );

   assign rsp_pressed_flags = rsp_rd.pressed_flags;
   assign rsp_debounced_up  = rsp_rd.debounced_up;
   assign rsp_beep_request  = rsp_rd.beep_request;

endmodule

FILE: hw/rtl/ksda_fifo.sv
module ksda_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign rdata   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

FILE: hw/rtl/ksda_front.sv
module ksda_front
   import ksda_pkg::*;
#(
   parameter int KEYS = 8
) (
   input  logic                push,
   output logic                full,
   input  logic                action,
   input  logic [KEY_W-1:0]    key_index,
   input  logic [SAMPLE_W-1:0] high_samples,
   output logic                cmd_push,
   output cmd_type             cmd,
   input  logic                cmd_full
);

   assign full     = cmd_full;
   assign cmd_push = push & ~cmd_full;

   always_comb begin
      cmd.clear   = (action == ACTION_CLEAR);
      cmd.key_ok  = ({1'b0, key_index} < (KEY_W + 1)'(KEYS));
      cmd.key     = key_index;
      cmd.go_up   = (high_samples > UP_ABOVE);
      cmd.go_down = (high_samples < DOWN_BELOW);
   end

endmodule

FILE: hw/rtl/ksda_back.sv
module ksda_back
   import ksda_pkg::*;
#(
   parameter int KEYS = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               cmd_empty,
   input  cmd_type            cmd,
   output logic               cmd_pop,
   input  logic               rsp_full,
   output logic               rsp_push,
   output rsp_type            rsp,
   input  logic [DELAY_W-1:0] reload,
   input  logic [COUNT_W-1:0] limit
);

   localparam int IDX_W = (KEYS > 1) ? $clog2(KEYS) : 1;

   logic [FLAG_W-1:0]  level_ff, level_in;
   logic [FLAG_W-1:0]  event_ff, event_in;
   logic [COUNT_W-1:0] hold_ff [KEYS];
   logic [COUNT_W-1:0] hold_in, hold_next;
   logic               hold_we;
   logic [IDX_W-1:0]   idx;
   logic [FLAG_W-1:0]  mask;
   logic               was_up, now_up, fire;
   beep_type           beep;

   assign fire     = ~cmd_empty & ~rsp_full;
   assign cmd_pop  = fire;
   assign rsp_push = fire;
   assign idx      = cmd.key[IDX_W-1:0];
   assign mask     = FLAG_W'(1) << cmd.key;
   assign was_up   = level_ff[cmd.key];

   always_comb begin
      level_in  = level_ff;
      event_in  = event_ff;
      hold_we   = 1'b0;
      hold_next = hold_ff[idx] + 1'b1;
      hold_in   = hold_next;
      beep      = BEEP_NONE;
      now_up    = cmd.go_up | (was_up & ~cmd.go_down);
      if (cmd.clear) begin
         event_in = '0;
      end else if (cmd.key_ok) begin
         level_in = now_up ? (level_ff | mask) : (level_ff & ~mask);
         if (now_up && !was_up) begin
            // release edge
            event_in = event_ff | mask;
            hold_in  = '0;
            hold_we  = 1'b1;
         end else if (!now_up && was_up) begin
            beep = BEEP_LONG;
         end else if (!now_up && !was_up) begin
            hold_we = 1'b1;
            if (limit < hold_next) begin
               // auto repeat fires
               event_in = event_ff | mask;
               hold_in  = COUNT_W'(reload);
               beep     = BEEP_SHORT;
            end
         end
      end
   end

   always_comb begin
      rsp.pressed_flags = event_in;
      rsp.debounced_up  = level_in;
      rsp.beep_request  = beep;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= '1;
         event_ff <= '0;
         for (int i = 0; i < KEYS; i++) begin
            hold_ff[i] <= '0;
         end
      end else if (fire) begin
         level_ff <= level_in;
         event_ff <= event_in;
         if (hold_we) begin
            hold_ff[idx] <= hold_in;
         end
      end
   end

endmodule
